// ----- sv/tle_pkg.sv -----
package tle_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int CW = $clog2(BUFFER_DEPTH);

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_CTRL_MAX = 8'h1F;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_BRACKET  = 8'h5B;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

    typedef logic [CW-1:0] addr_t;

    typedef enum logic [2:0] {
        OP_READ,
        OP_LF,
        OP_BS,
        OP_PRINT,
        OP_RIGHT,
        OP_LEFT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_GOT_ESC,
        ESC_GOT_BRACKET,
        ESC_SKIP
    } esc_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_RIGHT,
        BK_SHIFT,
        BK_TAIL,
        BK_EMIT,
        BK_ARROW
    } back_state_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic logic [7:0] sat_len(addr_t v);
        logic [CW+7:0] w;
        w = {8'd0, v};
        if (w > (CW+8)'(255))
            return 8'hFF;
        return w[7:0];
    endfunction

    function automatic logic byte_in_range(logic [7:0] b);
        logic [CW+7:0] w;
        w = {{CW{1'b0}}, b};
        return w < (CW+8)'(BUFFER_DEPTH);
    endfunction

    function automatic addr_t byte_to_addr(logic [7:0] b);
        logic [CW+7:0] w;
        w = {{CW{1'b0}}, b};
        return w[CW-1:0];
    endfunction

endpackage

// ----- sv/tle_ram.sv -----
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/tle_front.sv -----
module tle_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          kind,
    input  logic [7:0]    rx_byte,
    input  logic [7:0]    read_index,
    input  logic          q_full,
    input  logic          clearing,
    output logic          push,
    output tle_pkg::cmd_t push_cmd
);
    import tle_pkg::*;

    esc_t esc_reg;
    esc_t esc_next;
    logic hit;
    logic accept;

    assign in_stall = q_full || clearing;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && hit;

    always_comb
    begin
        esc_next      = esc_reg;
        hit           = 1'b0;
        push_cmd.op   = OP_READ;
        push_cmd.data = rx_byte;
        if (kind)
        begin
            hit           = 1'b1;
            push_cmd.data = read_index;
        end
        else
        begin
            case (esc_reg)
                ESC_IDLE:
                begin
                    if (rx_byte == CH_LF)
                    begin
                        hit         = 1'b1;
                        push_cmd.op = OP_LF;
                    end
                    else if (rx_byte == CH_BS)
                    begin
                        hit         = 1'b1;
                        push_cmd.op = OP_BS;
                    end
                    else if (rx_byte == CH_ESC)
                    begin
                        esc_next = ESC_GOT_ESC;
                    end
                    else if (rx_byte > CH_CTRL_MAX && rx_byte < CH_DEL)
                    begin
                        hit         = 1'b1;
                        push_cmd.op = OP_PRINT;
                    end
                end
                ESC_GOT_ESC:
                begin
                    esc_next = (rx_byte == CH_BRACKET) ? ESC_GOT_BRACKET : ESC_SKIP;
                end
                ESC_GOT_BRACKET:
                begin
                    if (rx_byte == CH_RIGHT || rx_byte == CH_LEFT)
                    begin
                        hit         = 1'b1;
                        push_cmd.op = (rx_byte == CH_RIGHT) ? OP_RIGHT : OP_LEFT;
                        esc_next    = ESC_IDLE;
                    end
                    else
                    begin
                        esc_next = is_letter(rx_byte) ? ESC_IDLE : ESC_SKIP;
                    end
                end
                default:
                begin
                    if (is_letter(rx_byte))
                    begin
                        esc_next = ESC_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esc_reg <= ESC_IDLE;
        end
        else if (accept)
        begin
            esc_reg <= esc_next;
        end
    end

endmodule

// ----- sv/tle_cmd_queue.sv -----
module tle_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tle_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          q_valid,
    output tle_pkg::cmd_t q_cmd
);
    import tle_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/tle_back.sv -----
module tle_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  tle_pkg::cmd_t q_cmd,
    output logic          pop,
    output logic          clearing,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    out_byte,
    output logic          is_read_data,
    output logic          line_done,
    output logic [7:0]    line_length,
    output logic          last
);
    import tle_pkg::*;

    back_state_t state_reg, state_next;
    addr_t       cursor_reg, cursor_next;
    addr_t       clr_reg, clr_next;
    logic [CW:0] sh_reg, sh_next;
    addr_t       wa_reg, wa_next;
    logic        pend_reg, pend_next;
    logic [7:0]  res_byte_reg, res_byte_next;
    logic        res_rd_reg, res_rd_next;
    logic        res_done_reg, res_done_next;
    logic [7:0]  res_len_reg, res_len_next;
    logic [1:0]  step_reg, step_next;
    logic [7:0]  arrow_reg, arrow_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        out_rd_reg, out_rd_next;
    logic        out_done_reg, out_done_next;
    logic [7:0]  out_len_reg, out_len_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic        ram_we;
    addr_t       ram_waddr;
    logic [7:0]  ram_wdata;
    addr_t       ram_raddr;
    logic [7:0]  ram_rdata;
    logic [CW:0] sh_dec;

    tle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free     = !out_valid_reg || !out_stall;
    assign clearing     = (state_reg == BK_CLEAR);
    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign is_read_data = out_rd_reg;
    assign line_done    = out_done_reg;
    assign line_length  = out_len_reg;
    assign last         = out_last_reg;
    assign sh_dec       = sh_reg - (CW+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        clr_next       = clr_reg;
        sh_next        = sh_reg;
        wa_next        = wa_reg;
        pend_next      = pend_reg;
        res_byte_next  = res_byte_reg;
        res_rd_next    = res_rd_reg;
        res_done_next  = res_done_reg;
        res_len_next   = res_len_reg;
        step_next      = step_reg;
        arrow_next     = arrow_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        out_rd_next    = out_rd_reg;
        out_done_next  = out_done_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cursor_reg;
        ram_wdata      = 8'd0;
        ram_raddr      = cursor_reg;

        case (state_reg)
            BK_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == addr_t'(BUFFER_DEPTH - 1))
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + addr_t'(1);
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    pop           = 1'b1;
                    res_rd_next   = 1'b0;
                    res_done_next = 1'b0;
                    res_len_next  = 8'd0;
                    step_next     = 2'd0;
                    arrow_next    = q_cmd.data;
                    case (q_cmd.op)
                        OP_READ:
                        begin
                            res_rd_next   = 1'b1;
                            res_byte_next = 8'd0;
                            ram_raddr     = byte_to_addr(q_cmd.data);
                            state_next    = byte_in_range(q_cmd.data) ? BK_READ : BK_EMIT;
                        end
                        OP_LF:
                        begin
                            ram_we        = 1'b1;
                            res_byte_next = CH_LF;
                            res_done_next = 1'b1;
                            res_len_next  = sat_len(cursor_reg);
                            cursor_next   = '0;
                            state_next    = BK_EMIT;
                        end
                        OP_BS:
                        begin
                            // shift reads start at the old cursor, writes land one below
                            if (cursor_reg != '0)
                            begin
                                cursor_next   = cursor_reg - addr_t'(1);
                                sh_next       = {1'b0, cursor_reg};
                                pend_next     = 1'b0;
                                res_byte_next = CH_BS;
                                state_next    = BK_SHIFT;
                            end
                        end
                        OP_PRINT:
                        begin
                            if (cursor_reg != addr_t'(BUFFER_DEPTH - 1))
                            begin
                                ram_we        = 1'b1;
                                ram_wdata     = q_cmd.data;
                                res_byte_next = q_cmd.data;
                                cursor_next   = cursor_reg + addr_t'(1);
                                state_next    = BK_EMIT;
                            end
                        end
                        OP_RIGHT:
                        begin
                            state_next = BK_RIGHT;
                        end
                        OP_LEFT:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - addr_t'(1);
                            end
                            state_next = BK_ARROW;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                res_byte_next = ram_rdata;
                state_next    = BK_EMIT;
            end
            BK_RIGHT:
            begin
                if (cursor_reg != addr_t'(BUFFER_DEPTH - 1) && ram_rdata != 8'd0)
                begin
                    cursor_next = cursor_reg + addr_t'(1);
                end
                state_next = BK_ARROW;
            end
            BK_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                if (sh_reg != (CW+1)'(BUFFER_DEPTH))
                begin
                    ram_raddr = sh_reg[CW-1:0];
                    wa_next   = sh_dec[CW-1:0];
                    pend_next = 1'b1;
                    sh_next   = sh_reg + (CW+1)'(1);
                end
                else
                begin
                    state_next = BK_TAIL;
                end
            end
            BK_TAIL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = addr_t'(BUFFER_DEPTH - 1);
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_rd_next    = res_rd_reg;
                    out_done_next  = res_done_reg;
                    out_len_next   = res_len_reg;
                    out_last_next  = 1'b1;
                    state_next     = BK_IDLE;
                end
            end
            BK_ARROW:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rd_next    = 1'b0;
                    out_done_next  = 1'b0;
                    out_len_next   = 8'd0;
                    out_last_next  = (step_reg == 2'd2);
                    case (step_reg)
                        2'd0:    out_byte_next = CH_ESC;
                        2'd1:    out_byte_next = CH_BRACKET;
                        default: out_byte_next = arrow_reg;
                    endcase
                    if (step_reg == 2'd2)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sh_reg       <= sh_next;
        wa_reg       <= wa_next;
        res_byte_reg <= res_byte_next;
        res_rd_reg   <= res_rd_next;
        res_done_reg <= res_done_next;
        res_len_reg  <= res_len_next;
        arrow_reg    <= arrow_next;
        out_byte_reg <= out_byte_next;
        out_rd_reg   <= out_rd_next;
        out_done_reg <= out_done_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            cursor_reg    <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            step_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/terminal_line_editor_core.sv -----
// Terminal line editor: received terminal bytes edit a line buffer at a cursor and
// produce echo bytes; a read transaction returns one buffer byte. After reset the
// core sweeps the line buffer to zero, one entry per cycle, and holds in_stall high
// meanwhile. A front stage takes one input transaction per cycle while in_stall is
// low, tracks the escape sequence state and drops bytes that cause no effect; work
// goes through a two-entry command queue to the back end, which owns the
// single-port-write line RAM. Printable bytes and line feed go from BK_IDLE to
// BK_EMIT, in-range reads pass through BK_READ, cursor left goes to BK_ARROW and
// cursor right passes through BK_RIGHT; BK_ARROW sends the 3-byte cursor echo one
// byte at a time. Backspace moves the buffer tail one entry at a time through the
// RAM read and write ports and is the slowest command. Results leave through an
// output register, so the back end keeps working while a result waits on out_stall.
module terminal_line_editor_core (
    input  logic       clk,
    input  logic       rst_n,
    // input transactions
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] rx_byte,
    input  logic [7:0] read_index,
    // result transactions
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       is_read_data,
    output logic       line_done,
    output logic [7:0] line_length,
    output logic       last
);
    import tle_pkg::*;

    // command handoff between front and back
    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_cmd;
    logic pop;
    // back end busy clearing the buffer after reset
    logic clearing;

    // escape tracking and classification of each received byte
    tle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .q_full     (q_full),
        .clearing   (clearing),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // decouples byte intake from long buffer operations
    tle_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // buffer edits, cursor, echo generation and output register
    tle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_read_data (is_read_data),
        .line_done    (line_done),
        .line_length  (line_length),
        .last         (last)
    );

endmodule

// ----- sv/tle_checker.sv -----
module tle_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       is_read_data,
    input logic       line_done,
    input logic       last
);
    import tle_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last))
        else $error("result changed under stall");

    // line end is a single final line feed echo
    a_line_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> out_byte == CH_LF && !is_read_data && last)
        else $error("bad line end result");

    // read answers are single transactions
    a_read_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_read_data |-> last && !line_done)
        else $error("read answer not single");

    // a cursor echo continues without a gap
    a_echo_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid && !is_read_data && !line_done)
        else $error("echo sequence broken");

endmodule

bind terminal_line_editor_core tle_checker u_tle_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .is_read_data (is_read_data),
    .line_done    (line_done),
    .last         (last)
);

// ----- bench/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tle_pkg::*;

    // transaction kinds on the input channel
    localparam logic KIND_EDIT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam int IDLE_PERCENT   = 16;
    localparam int RANDOM_ITEMS   = 24;
    // cycles with no transaction on either side before the run is abandoned
    localparam int WATCHDOG_LIMIT = 5000;
    // drain time at the end, after every expected result has come back
    localparam int SETTLE_CYCLES  = 400;

    // one result transaction as seen on the output ports
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_read_data;
        logic       line_done;
        logic [7:0] line_length;
        logic       last;
    } echo_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       is_read_data;
    logic       line_done;
    logic [7:0] line_length;
    logic       last;

    // shadow copy of the editor: line contents, cursor and escape parser
    logic [7:0]  shadow_line [BUFFER_DEPTH];
    int unsigned shadow_cursor;
    esc_t        shadow_esc;

    echo_t pending_echoes[$];
    echo_t oldest_echo;

    // no random idling on either side while set
    bit quiet;

    int fail_count;
    int items_sent;
    int reads_sent;
    int results_seen;
    int lines_seen;
    int longest_line;
    int idle_cycles;

    terminal_line_editor_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .is_read_data (is_read_data),
        .line_done    (line_done),
        .line_length  (line_length),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------

    function automatic logic ascii_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic void queue_echo(logic [7:0] b, logic rd, logic done,
                                       logic [7:0] len, logic fin);
        echo_t e;
        e.out_byte     = b;
        e.is_read_data = rd;
        e.line_done    = done;
        e.line_length  = len;
        e.last         = fin;
        pending_echoes.push_back(e);
    endfunction

    // advance the shadow editor by one accepted input transaction and queue
    // the echo bytes or read data it produces
    function automatic void apply_terminal_item(logic k, logic [7:0] c, logic [7:0] ix);
        int unsigned pos;
        if (k == KIND_READ)
        begin
            queue_echo((ix < BUFFER_DEPTH) ? shadow_line[ix] : 8'h00, 1'b1, 1'b0, 8'h00, 1'b1);
            return;
        end
        case (shadow_esc)
            ESC_IDLE:
            begin
                if (c == CH_LF)
                begin
                    // terminate at the cursor, report its position, home it
                    queue_echo(CH_LF, 1'b0, 1'b1,
                               (shadow_cursor > 255) ? 8'hFF : 8'(shadow_cursor), 1'b1);
                    if (shadow_cursor > longest_line)
                        longest_line = shadow_cursor;
                    shadow_line[shadow_cursor] = 8'h00;
                    shadow_cursor = 0;
                end
                else if (c == CH_BS)
                begin
                    // nothing to delete at line start
                    if (shadow_cursor != 0)
                    begin
                        shadow_cursor--;
                        for (pos = shadow_cursor; pos + 1 < BUFFER_DEPTH; pos++)
                            shadow_line[pos] = shadow_line[pos + 1];
                        shadow_line[BUFFER_DEPTH - 1] = 8'h00;
                        queue_echo(CH_BS, 1'b0, 1'b0, 8'h00, 1'b1);
                    end
                end
                else if (c == CH_ESC)
                    shadow_esc = ESC_GOT_ESC;
                else if (c > CH_CTRL_MAX && c < CH_DEL && shadow_cursor < BUFFER_DEPTH - 1)
                begin
                    // printable byte, dropped once the buffer is full
                    shadow_line[shadow_cursor] = c;
                    shadow_cursor++;
                    queue_echo(c, 1'b0, 1'b0, 8'h00, 1'b1);
                end
            end
            ESC_GOT_ESC:
                shadow_esc = (c == CH_BRACKET) ? ESC_GOT_BRACKET : ESC_SKIP;
            ESC_GOT_BRACKET:
            begin
                if (c == CH_RIGHT || c == CH_LEFT)
                begin
                    // right only past a written entry, left stops at zero
                    if (c == CH_RIGHT)
                    begin
                        if (shadow_cursor < BUFFER_DEPTH - 1 && shadow_line[shadow_cursor] != 0)
                            shadow_cursor++;
                    end
                    else if (shadow_cursor > 0)
                        shadow_cursor--;
                    shadow_esc = ESC_IDLE;
                    queue_echo(CH_ESC, 1'b0, 1'b0, 8'h00, 1'b0);
                    queue_echo(CH_BRACKET, 1'b0, 1'b0, 8'h00, 1'b0);
                    queue_echo(c, 1'b0, 1'b0, 8'h00, 1'b1);
                end
                else
                    shadow_esc = ascii_alpha(c) ? ESC_IDLE : ESC_SKIP;
            end
            default:
            begin
                // skipping until a letter
                if (ascii_alpha(c))
                    shadow_esc = ESC_IDLE;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // input side: every task here starts and ends at a falling edge
    // ---------------------------------------------------------------

    task automatic send_item(input logic k, input logic [7:0] b, input logic [7:0] ix);
        // random gap ahead of the transaction
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        kind       = k;
        rx_byte    = b;
        read_index = ix;
        // payload held until the core takes it
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        apply_terminal_item(k, b, ix);
        items_sent++;
        if (k == KIND_READ)
            reads_sent++;
        @(negedge clk);
    endtask

    // unused payload fields carry random values so every bit toggles
    task automatic send_key(input logic [7:0] b);
        send_item(KIND_EDIT, b, 8'($urandom_range(255)));
    endtask

    task automatic send_read(input logic [7:0] ix);
        send_item(KIND_READ, 8'($urandom_range(255)), ix);
    endtask

    task automatic send_arrow(input logic [7:0] dir);
        send_key(CH_ESC);
        send_key(CH_BRACKET);
        send_key(dir);
    endtask

    // sender holds off until every queued result has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_echoes.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(1))
            return 8'($urandom_range(8'h5A, 8'h41));
        return 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    task automatic test_printable_echo();
        send_key(CH_CTRL_MAX + 8'd1);   // lowest printable
        send_key(CH_DEL - 8'd1);        // highest printable
        send_read(8'd0);
        send_read(8'hFF);               // never written
    endtask

    task automatic test_cursor_keys();
        send_arrow(CH_RIGHT);           // entry under cursor is empty, no move
        send_arrow(CH_LEFT);
    endtask

    task automatic test_backspace();
        send_key(CH_BS);                // tail shifts left onto entry 0
        send_read(8'd0);
        send_key(CH_BS);                // at line start, ignored
    endtask

    task automatic test_line_feed();
        send_key(CH_LF);                // empty line
        send_arrow(CH_LEFT);            // left at zero still echoes
    endtask

    task automatic test_escape_skip();
        // esc then a non-bracket byte: skip up to the letter
        send_key(CH_ESC);
        send_key(8'h78);
        send_key(8'h71);
        // unsupported final letter ends the sequence silently
        send_key(CH_ESC);
        send_key(CH_BRACKET);
        send_key(CH_UPPER_A);
        // parameter digit inside the sequence, skipped to the letter
        send_key(CH_ESC);
        send_key(CH_BRACKET);
        send_key(8'h31);
        send_key(CH_LOWER_Z);
    endtask

    task automatic test_ignored_bytes();
        send_key(8'h00);
        send_key(CH_DEL);
        send_key(8'hFF);
    endtask

    // fill one line to the end of the buffer, then poke at the full state
    task automatic test_full_line();
        send_key(CH_LF);
        while (shadow_cursor < BUFFER_DEPTH - 1)
            send_key(8'($urandom_range(CH_DEL - 1, CH_CTRL_MAX + 1)));
        send_key(8'($urandom_range(CH_DEL - 1, CH_CTRL_MAX + 1)));  // dropped, no room
        send_arrow(CH_RIGHT);                                       // already at the end
        send_read(8'(BUFFER_DEPTH - 1));
        send_key(CH_LF);                                            // longest line length
        send_arrow(CH_RIGHT);
        send_key(CH_BS);                                            // shifts the whole buffer
        send_read(8'd0);
        send_read(8'(BUFFER_DEPTH - 2));
    endtask

    // mostly well-formed editing with random content, some noise
    task automatic test_random_editing();
        int         n;
        int         pick;
        logic [7:0] b;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet = (n >= 8 && n < 20);
            if (n == 4)
                wait_drained();
            pick = $urandom_range(99);
            if (pick < 35)
                send_key(8'($urandom_range(CH_DEL - 1, CH_CTRL_MAX + 1)));
            else if (pick < 47)
                send_key(CH_BS);
            else if (pick < 55)
                send_key(CH_LF);
            else if (pick < 70)
                send_arrow($urandom_range(1) ? CH_RIGHT : CH_LEFT);
            else if (pick < 82)
            begin
                if ($urandom_range(1))
                    send_read(8'($urandom_range(shadow_cursor + 1 > 255 ? 255 :
                                                shadow_cursor + 1)));
                else
                    send_read(8'($urandom_range(255)));
            end
            else if (pick < 90)
            begin
                send_key(CH_ESC);
                case ($urandom_range(2))
                    0:
                    begin
                        send_key(CH_BRACKET);
                        do
                            b = rand_letter();
                        while (b == CH_RIGHT || b == CH_LEFT);
                        send_key(b);
                    end
                    1:
                    begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == CH_BRACKET);
                        send_key(b);
                        send_key(rand_letter());
                    end
                    default:
                    begin
                        send_key(CH_BRACKET);
                        send_key(8'($urandom_range(8'h39, 8'h30)));
                        send_key(rand_letter());
                    end
                endcase
            end
            else
                send_key(8'($urandom_range(255)));
        end
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // random backpressure on the result channel
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %02h, got %02h", name, want, got);
            fail_count++;
        end
    endfunction

    // each accepted result against the oldest queued expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (line_done === 1'b1)
                lines_seen++;
            if (pending_echoes.size() == 0)
            begin
                $error("result transaction with nothing expected: out_byte %02h", out_byte);
                fail_count++;
            end
            else
            begin
                oldest_echo = pending_echoes.pop_front();
                check_field("out_byte", oldest_echo.out_byte, out_byte);
                check_field("is_read_data", 8'(oldest_echo.is_read_data), 8'(is_read_data));
                check_field("line_done", 8'(oldest_echo.line_done), 8'(line_done));
                check_field("line_length", oldest_echo.line_length, line_length);
                check_field("last", 8'(oldest_echo.last), 8'(last));
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_echoes.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        kind       = KIND_EDIT;
        rx_byte    = 8'h00;
        read_index = 8'h00;
        quiet      = 1'b0;
        foreach (shadow_line[i])
            shadow_line[i] = 8'h00;
        shadow_cursor = 0;
        shadow_esc    = ESC_IDLE;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // core holds in_stall through its buffer sweep, send_item waits it out
        test_printable_echo();
        test_cursor_keys();
        test_backspace();
        test_line_feed();
        test_escape_skip();
        test_ignored_bytes();
        wait_drained();
        test_full_line();
        test_random_editing();

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_echoes.size() != 0)
        begin
            $error("%0d expected result transactions never arrived", pending_echoes.size());
            fail_count++;
        end

        $display("covered %0d input transactions (%0d reads) and %0d result transactions",
                 items_sent, reads_sent, results_seen);
        $display("%0d lines terminated, longest %0d bytes, full-buffer and escape paths hit",
                 lines_seen, longest_line);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tle_pkg.sv
sv/tle_ram.sv
sv/tle_front.sv
sv/tle_cmd_queue.sv
sv/tle_back.sv
sv/terminal_line_editor_core.sv
sv/tle_checker.sv
bench/tb_top.sv
